>>> rtl/core/ritd_pkg.sv
// ----------------------------------------------------------------------------
// ritd_pkg: shared types and constants
// Request kinds, address map, prescale table and the item and result records
// passed between the stages of the RAM, I/O and timer device.
// ----------------------------------------------------------------------------
package ritd_pkg;

	typedef enum logic [1:0] {
		REQ_READ  = 2'd0,
		REQ_WRITE = 2'd1,
		REQ_TICK  = 2'd2
	} req_t;

	// Offsets at or above this value leave the RAM window
	localparam logic [7:0] RAM_LIMIT     = 8'h80;
	localparam logic [7:0] ADDR_PA_DATA  = 8'h80;
	localparam logic [7:0] ADDR_PA_DIR   = 8'h81;
	localparam logic [7:0] ADDR_PB_DATA  = 8'h82;
	localparam logic [7:0] ADDR_PB_DIR   = 8'h83;
	localparam logic [7:0] ADDR_FLAG     = 8'h85;
	localparam logic [7:0] ADDR_TMR_LO   = 8'h94;
	localparam logic [7:0] ADDR_TMR_HI   = 8'h97;
	localparam logic [7:0] ADDR_TMRI_LO  = 8'h9C;
	localparam logic [7:0] ADDR_TMRI_HI  = 8'h9F;

	localparam logic [7:0] FLAG_EXPIRED  = 8'h80;
	localparam logic [7:0] COUNT_WRAP    = 8'hFF;

	typedef logic [9:0] presc_cnt_t;

	// Prescale period, returned one wider than the counter so 1024 fits
	function automatic logic [10:0] presc_period(input logic [1:0] sel);
		logic [10:0] p;
		case (sel)
			2'd0:    p = 11'd1;
			2'd1:    p = 11'd8;
			2'd2:    p = 11'd64;
			default: p = 11'd1024;
		endcase
		return p;
	endfunction

	typedef struct packed {
		req_t       req;
		logic [7:0] addr;
		logic [7:0] wdata;
	} item_t;

	typedef struct packed {
		logic [7:0] port_b;
		logic [7:0] port_a;
		logic       irq;
		logic [7:0] rdata;
	} result_t;

endpackage

>>> rtl/core/ritd_ram.sv
// ----------------------------------------------------------------------------
// ritd_ram: scratch RAM
// Single-port RAM with registered read and per-entry valid bits so that an
// entry never written since reset reads as zero.
// ----------------------------------------------------------------------------
module ritd_ram #(
	parameter int DEPTH = 128
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       en,
	input  logic       we,
	input  logic [6:0] addr,
	input  logic [7:0] wdata,
	output logic [7:0] rdata
);

	localparam int AW = $clog2(DEPTH);

	logic [7:0]       mem [DEPTH];
	logic [DEPTH-1:0] valid_q;
	logic [7:0]       rd_q;
	logic             rd_valid_q;
	logic [AW-1:0]    idx;

	// Fold the 7-bit offset into the RAM depth: with at least 16 entries the
	// quotient is below 8, so three compare-and-subtract steps cover it
	function automatic logic [AW-1:0] fold(input logic [6:0] a);
		logic [9:0] v;
		v = {3'b000, a};
		for (int k = 2; k >= 0; k--) begin
			if (v >= (10'(DEPTH) << k)) begin
				v = v - (10'(DEPTH) << k);
			end
		end
		return v[AW-1:0];
	endfunction

	assign idx = fold(addr);

	always_ff @(posedge clk) begin
		if (en) begin
			if (we) begin
				mem[idx] <= wdata;
			end
			rd_q <= mem[idx];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q    <= '0;
			rd_valid_q <= 1'b0;
		end else if (en) begin
			if (we) begin
				valid_q[idx] <= 1'b1;
			end
			rd_valid_q <= valid_q[idx];
		end
	end

	assign rdata = rd_valid_q ? rd_q : 8'h00;

endmodule

>>> rtl/core/ritd_core.sv
// ----------------------------------------------------------------------------
// ritd_core: port latches, interval timer and result register
// Decodes one item per advance, updates the ports and timer state and loads
// the result register.
// ----------------------------------------------------------------------------
module ritd_core (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              advance,
	input  ritd_pkg::item_t   item,
	input  logic [7:0]        ram_rdata,
	output ritd_pkg::result_t result
);

	logic [7:0]           pa_q, pa_dir_q, pb_q, pb_dir_q;
	logic [7:0]           count_q;
	logic [1:0]           sel_q;
	ritd_pkg::presc_cnt_t presc_q;
	logic                 expired_q, irq_en_q, irq_pend_q;
	ritd_pkg::result_t    result_q;

	logic [7:0]           pa_d, pa_dir_d, pb_d, pb_dir_d;
	logic [7:0]           count_d;
	logic [1:0]           sel_d;
	ritd_pkg::presc_cnt_t presc_d;
	logic                 expired_d, irq_en_d, irq_pend_d;
	logic [7:0]           rdata_d;
	logic [10:0]          presc_next;

	assign presc_next = {1'b0, presc_q} + 11'd1;

	always_comb begin
		pa_d       = pa_q;
		pa_dir_d   = pa_dir_q;
		pb_d       = pb_q;
		pb_dir_d   = pb_dir_q;
		count_d    = count_q;
		sel_d      = sel_q;
		presc_d    = presc_q;
		expired_d  = expired_q;
		irq_en_d   = irq_en_q;
		irq_pend_d = irq_pend_q;
		rdata_d    = 8'h00;
		case (item.req)
			ritd_pkg::REQ_READ: begin
				if (item.addr < ritd_pkg::RAM_LIMIT) begin
					rdata_d = ram_rdata;
				end else begin
					case (item.addr)
						ritd_pkg::ADDR_PA_DATA: rdata_d = pa_q;
						ritd_pkg::ADDR_PA_DIR:  rdata_d = pa_dir_q;
						ritd_pkg::ADDR_PB_DATA: rdata_d = pb_q;
						ritd_pkg::ADDR_PB_DIR:  rdata_d = pb_dir_q;
						ritd_pkg::ADDR_FLAG: begin
							rdata_d    = expired_q ? ritd_pkg::FLAG_EXPIRED : 8'h00;
							expired_d  = 1'b0;
							irq_pend_d = 1'b0;
						end
						default: rdata_d = 8'h00;
					endcase
				end
			end
			ritd_pkg::REQ_WRITE: begin
				case (item.addr)
					ritd_pkg::ADDR_PA_DATA: pa_d     = item.wdata;
					ritd_pkg::ADDR_PA_DIR:  pa_dir_d = item.wdata;
					ritd_pkg::ADDR_PB_DATA: pb_d     = item.wdata;
					ritd_pkg::ADDR_PB_DIR:  pb_dir_d = item.wdata;
					default: begin
						// Timer start: low two offset bits pick the prescale
						if (item.addr inside {[ritd_pkg::ADDR_TMR_LO:ritd_pkg::ADDR_TMR_HI],
						                      [ritd_pkg::ADDR_TMRI_LO:ritd_pkg::ADDR_TMRI_HI]}) begin
							count_d    = item.wdata;
							sel_d      = item.addr[1:0];
							presc_d    = '0;
							irq_en_d   = item.addr[3];
							expired_d  = 1'b0;
							irq_pend_d = 1'b0;
						end
					end
				endcase
			end
			ritd_pkg::REQ_TICK: begin
				if (expired_q) begin
					count_d = count_q - 8'd1;
				end else if (presc_next < ritd_pkg::presc_period(sel_q)) begin
					presc_d = presc_next[9:0];
				end else begin
					presc_d = '0;
					if (count_q != 8'h00) begin
						count_d = count_q - 8'd1;
					end else begin
						expired_d = 1'b1;
						count_d   = ritd_pkg::COUNT_WRAP;
						if (irq_en_q) begin
							irq_pend_d = 1'b1;
						end
					end
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pa_q       <= 8'h00;
			pa_dir_q   <= 8'h00;
			pb_q       <= 8'h00;
			pb_dir_q   <= 8'h00;
			count_q    <= 8'h00;
			sel_q      <= 2'd0;
			presc_q    <= '0;
			expired_q  <= 1'b0;
			irq_en_q   <= 1'b0;
			irq_pend_q <= 1'b0;
		end else if (advance) begin
			pa_q       <= pa_d;
			pa_dir_q   <= pa_dir_d;
			pb_q       <= pb_d;
			pb_dir_q   <= pb_dir_d;
			count_q    <= count_d;
			sel_q      <= sel_d;
			presc_q    <= presc_d;
			expired_q  <= expired_d;
			irq_en_q   <= irq_en_d;
			irq_pend_q <= irq_pend_d;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			result_q.rdata  <= rdata_d;
			result_q.irq    <= irq_pend_d;
			result_q.port_a <= pa_d;
			result_q.port_b <= pb_d;
		end
	end

	assign result = result_q;

	a_pend_needs_flag: assert property (@(posedge clk) disable iff (!arst_n)
		irq_pend_q |-> (expired_q && irq_en_q))
		else $error("irq pending without expired flag and enable");

	a_presc_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		({1'b0, presc_q} < ritd_pkg::presc_period(sel_q)))
		else $error("prescale counter beyond its period");

endmodule

>>> rtl/core/ram_io_timer_device.sv
// ----------------------------------------------------------------------------
// ram_io_timer_device: RAM, I/O ports and interval timer
// Streaming front end with input stage, RAM and result register.
// ----------------------------------------------------------------------------
// Usage:
//   Slave side carries one request per transfer: tuser is the request kind
//   (read, write, timer tick), tdata holds the bus offset and write byte.
//   Master side returns exactly one result per request: the read byte, the
//   pending timer interrupt and both port data latches after the request.
//   Input stage and result register lie between transfer and result valid.
//   One request is taken every cycle while results drain; the RAM read is
//   issued at transfer; timer and port update is one pass in the core stage.
//   When the receiver stalls, the result register holds, the input stage
//   fills, and s_tready drops after one more transfer; nothing is lost.
//   Reset clears ports, direction latches, timer state and the RAM valid
//   bits, so the whole RAM reads as zero right after reset.
// ----------------------------------------------------------------------------
module ram_io_timer_device #(
	parameter int RAM_DEPTH = 128
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [15:0] s_tdata,   // [7:0] address, [15:8] write_data
	input  logic [1:0]  s_tuser,   // [1:0] req_type
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [31:0] m_tdata    // [7:0] read_data, [8] irq_out,
	                               // [16:9] port_a_out, [24:17] port_b_out
);

	ritd_pkg::item_t   item_in, item_s1;
	ritd_pkg::result_t result;
	logic              s1_valid_q, out_valid_q;
	logic              in_xfer, advance, ram_en;
	logic [7:0]        ram_rdata;

	assign item_in.req   = ritd_pkg::req_t'(s_tuser);
	assign item_in.addr  = s_tdata[7:0];
	assign item_in.wdata = s_tdata[15:8];

	assign advance  = s1_valid_q && (!out_valid_q || m_tready);
	assign s_tready = !s1_valid_q || advance;
	assign in_xfer  = s_tvalid && s_tready;

	// RAM is touched at the input transfer so its read data lines up with s1
	assign ram_en = in_xfer && (item_in.addr < ritd_pkg::RAM_LIMIT) &&
	                (item_in.req == ritd_pkg::REQ_READ || item_in.req == ritd_pkg::REQ_WRITE);

	ritd_ram #(
		.DEPTH(RAM_DEPTH)
	) u_ram (
		.clk   (clk),
		.arst_n(arst_n),
		.en    (ram_en),
		.we    (item_in.req == ritd_pkg::REQ_WRITE),
		.addr  (item_in.addr[6:0]),
		.wdata (item_in.wdata),
		.rdata (ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q  <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (in_xfer) begin
				s1_valid_q <= 1'b1;
			end else if (advance) begin
				s1_valid_q <= 1'b0;
			end
			if (advance) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_xfer) begin
			item_s1 <= item_in;
		end
	end

	ritd_core u_core (
		.clk      (clk),
		.arst_n   (arst_n),
		.advance  (advance),
		.item     (item_s1),
		.ram_rdata(ram_rdata),
		.result   (result)
	);

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {7'd0, result.port_b, result.port_a, result.irq, result.rdata};

	a_empty_stage_ready: assert property (@(posedge clk) disable iff (!arst_n)
		!s1_valid_q |-> s_tready)
		else $error("input stage empty but not ready");

	a_xfer_fills_stage: assert property (@(posedge clk) disable iff (!arst_n)
		in_xfer |=> s1_valid_q)
		else $error("accepted request lost from input stage");

	a_advance_gives_result: assert property (@(posedge clk) disable iff (!arst_n)
		advance |=> m_tvalid)
		else $error("advanced request produced no result");

endmodule

>>> test/tb_ram_io_timer_device.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_ram_io_timer_device: self-checking bench for the RAM, I/O and timer device
// Drives bus reads, writes, timer ticks and unknown requests on the input
// stream and checks every result against a cycle-free model of the RAM, port
// latches and interval timer. Directed accesses come first, then timer runs
// with random content mixed with RAM and port traffic and random noise, over
// phases with and without sender gaps and receiver stalls.
// ----------------------------------------------------------------------------
module tb_ram_io_timer_device;

	localparam int RAM_WORDS  = 128;
	localparam int RAND_ITEMS = 500;
	localparam logic [1:0] REQ_UNKNOWN = 2'd3;

	typedef struct {
		logic [1:0] kind;
		logic [7:0] addr;
		logic [7:0] wdata;
	} bus_req_t;

	class riot_checker;
		logic [7:0] ram [RAM_WORDS];
		logic [7:0] pa_data, pa_dir, pb_data, pb_dir;
		logic [7:0] tmr_count;
		logic [1:0] tmr_sel;
		logic [9:0] presc_count;
		bit         expired, irq_en, irq_pend;
		ritd_pkg::result_t pending_results [$];
		int         errors;

		function new();
			foreach (ram[i])
				ram[i] = 8'h00;
			pa_data = 8'h00;
			pa_dir = 8'h00;
			pb_data = 8'h00;
			pb_dir = 8'h00;
			tmr_count = 8'h00;
			tmr_sel = 2'd0;
			presc_count = 10'd0;
			expired = 1'b0;
			irq_en = 1'b0;
			irq_pend = 1'b0;
			errors = 0;
		endfunction

		function int prescale_len(logic [1:0] sel);
			case (sel)
				2'd0: return 1;
				2'd1: return 8;
				2'd2: return 64;
				default: return 1024;
			endcase
		endfunction

		function void start_timer(logic [1:0] sel, logic [7:0] count, bit irq);
			tmr_count = count;
			tmr_sel = sel;
			presc_count = 10'd0;
			irq_en = irq;
			expired = 1'b0;
			irq_pend = 1'b0;
		endfunction

		function void tick_timer();
			if (expired) begin
				tmr_count = tmr_count - 8'd1;
			end else if (int'(presc_count) + 1 < prescale_len(tmr_sel)) begin
				presc_count = presc_count + 10'd1;
			end else begin
				presc_count = 10'd0;
				if (tmr_count != 8'h00) begin
					tmr_count = tmr_count - 8'd1;
				end else begin
					expired = 1'b1;
					if (irq_en)
						irq_pend = 1'b1;
					tmr_count = ritd_pkg::COUNT_WRAP;
				end
			end
		endfunction

		function logic [7:0] read_reg(logic [7:0] a);
			logic [7:0] v;
			v = 8'h00;
			if (a < ritd_pkg::RAM_LIMIT) begin
				v = ram[int'(a) % RAM_WORDS];
			end else begin
				case (a)
					ritd_pkg::ADDR_PA_DATA: v = pa_data;
					ritd_pkg::ADDR_PA_DIR:  v = pa_dir;
					ritd_pkg::ADDR_PB_DATA: v = pb_data;
					ritd_pkg::ADDR_PB_DIR:  v = pb_dir;
					ritd_pkg::ADDR_FLAG: begin
						v = expired ? ritd_pkg::FLAG_EXPIRED : 8'h00;
						expired = 1'b0;
						irq_pend = 1'b0;
					end
					default: v = 8'h00;
				endcase
			end
			return v;
		endfunction

		function void write_reg(logic [7:0] a, logic [7:0] d);
			if (a < ritd_pkg::RAM_LIMIT) begin
				ram[int'(a) % RAM_WORDS] = d;
			end else if (a == ritd_pkg::ADDR_PA_DATA) begin
				pa_data = d;
			end else if (a == ritd_pkg::ADDR_PA_DIR) begin
				pa_dir = d;
			end else if (a == ritd_pkg::ADDR_PB_DATA) begin
				pb_data = d;
			end else if (a == ritd_pkg::ADDR_PB_DIR) begin
				pb_dir = d;
			end else if (a >= ritd_pkg::ADDR_TMR_LO && a <= ritd_pkg::ADDR_TMR_HI) begin
				start_timer(2'(a - ritd_pkg::ADDR_TMR_LO), d, 1'b0);
			end else if (a >= ritd_pkg::ADDR_TMRI_LO && a <= ritd_pkg::ADDR_TMRI_HI) begin
				start_timer(2'(a - ritd_pkg::ADDR_TMRI_LO), d, 1'b1);
			end
		endfunction

		// Apply one accepted request and queue the result it produces
		function void note_item(bus_req_t r);
			ritd_pkg::result_t res;
			res.rdata = 8'h00;
			case (r.kind)
				ritd_pkg::REQ_READ:  res.rdata = read_reg(r.addr);
				ritd_pkg::REQ_WRITE: write_reg(r.addr, r.wdata);
				ritd_pkg::REQ_TICK:  tick_timer();
				default: ;
			endcase
			res.irq = irq_pend;
			res.port_a = pa_data;
			res.port_b = pb_data;
			pending_results.push_back(res);
		endfunction

		function void check_result(ritd_pkg::result_t got);
			ritd_pkg::result_t want;
			if (pending_results.size() == 0) begin
				$display("%0t: unexpected result %h", $time, got);
				errors++;
				return;
			end
			want = pending_results.pop_front();
			if (got.rdata !== want.rdata) begin
				$display("%0t: read_data expected %h actual %h", $time, want.rdata, got.rdata);
				errors++;
			end
			if (got.irq !== want.irq) begin
				$display("%0t: irq_out expected %b actual %b", $time, want.irq, got.irq);
				errors++;
			end
			if (got.port_a !== want.port_a) begin
				$display("%0t: port_a_out expected %h actual %h", $time, want.port_a,
					got.port_a);
				errors++;
			end
			if (got.port_b !== want.port_b) begin
				$display("%0t: port_b_out expected %h actual %h", $time, want.port_b,
					got.port_b);
				errors++;
			end
		endfunction

		function int outstanding();
			return pending_results.size();
		endfunction
	endclass

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [15:0] s_tdata = 16'h0000;
	logic [1:0]  s_tuser = 2'd0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [31:0] m_tdata;

	riot_checker sb = new();
	int          idle_pct = 0;
	int          stall_pct = 0;
	int          rand_sent = 0;

	ram_io_timer_device #(.RAM_DEPTH(RAM_WORDS)) u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(posedge clk) begin
		m_tready <= ($urandom_range(99) >= stall_pct);
	end

	// Note the input transfer before checking the output of the same edge
	always @(posedge clk) begin
		bus_req_t r;
		if (arst_n) begin
			if (s_tvalid && s_tready) begin
				r.kind = s_tuser;
				r.addr = s_tdata[7:0];
				r.wdata = s_tdata[15:8];
				sb.note_item(r);
			end
			if (m_tvalid && m_tready)
				sb.check_result(ritd_pkg::result_t'(m_tdata[24:0]));
		end
	end

	function automatic bus_req_t mk(logic [1:0] kind, logic [7:0] addr, logic [7:0] wdata);
		bus_req_t r;
		r.kind = kind;
		r.addr = addr;
		r.wdata = wdata;
		return r;
	endfunction

	// Hold valid across back-to-back transfers; drop it only for a gap
	task automatic send(bus_req_t r);
		while ($urandom_range(99) < idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser <= r.kind;
		s_tdata <= {r.wdata, r.addr};
		do
			@(posedge clk);
		while (!s_tready);
		rand_sent++;
	endtask

	task automatic misc_access();
		int pick;
		logic [7:0] a;
		pick = $urandom_range(99);
		if (pick < 40) begin
			a = 8'($urandom_range(127));
			send(mk($urandom_range(1) ? ritd_pkg::REQ_WRITE : ritd_pkg::REQ_READ, a,
				8'($urandom_range(255))));
		end else if (pick < 70) begin
			a = ritd_pkg::ADDR_PA_DATA + 8'($urandom_range(3));
			send(mk($urandom_range(1) ? ritd_pkg::REQ_WRITE : ritd_pkg::REQ_READ, a,
				8'($urandom_range(255))));
		end else if (pick < 85) begin
			send(mk(ritd_pkg::REQ_READ, ritd_pkg::ADDR_FLAG, 8'($urandom_range(255))));
		end else begin
			send(mk(2'($urandom_range(3)), 8'($urandom_range(255)),
				8'($urandom_range(255))));
		end
	endtask

	task automatic timer_run();
		int w, sel, cnt, period, nticks, i;
		bit irq;
		w = $urandom_range(99);
		sel = (w < 40) ? 0 : (w < 75) ? 1 : (w < 95) ? 2 : 3;
		irq = 1'($urandom_range(1));
		case (sel)
			0: cnt = $urandom_range(12);
			1: cnt = $urandom_range(6);
			2: cnt = $urandom_range(2);
			default: cnt = 0;
		endcase
		if ($urandom_range(9) == 0)
			cnt = $urandom_range(255);
		period = sel == 0 ? 1 : sel == 1 ? 8 : sel == 2 ? 64 : 1024;
		nticks = (cnt + 1) * period + $urandom_range(6);
		// Too slow to reach expiry: run part way and leave it
		if (nticks > 200)
			nticks = $urandom_range(120, 40);
		send(mk(ritd_pkg::REQ_WRITE,
			(irq ? ritd_pkg::ADDR_TMRI_LO : ritd_pkg::ADDR_TMR_LO) + 8'(sel), 8'(cnt)));
		for (i = 0; i < nticks; i++) begin
			if ($urandom_range(99) < 15)
				misc_access();
			send(mk(ritd_pkg::REQ_TICK, 8'($urandom_range(255)), 8'($urandom_range(255))));
		end
		if ($urandom_range(99) < 70)
			send(mk(ritd_pkg::REQ_READ, ritd_pkg::ADDR_FLAG, 8'h00));
	endtask

	initial begin
		int pick, n, i, phase;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// RAM ends, cleared at reset, then written and read back
		send(mk(ritd_pkg::REQ_READ, 8'h00, 8'h00));
		send(mk(ritd_pkg::REQ_READ, 8'h7F, 8'h00));
		send(mk(ritd_pkg::REQ_WRITE, 8'h00, 8'hFF));
		send(mk(ritd_pkg::REQ_WRITE, 8'h7F, 8'hA5));
		send(mk(ritd_pkg::REQ_READ, 8'h00, 8'h00));
		send(mk(ritd_pkg::REQ_READ, 8'h7F, 8'h00));
		// Port latches show data whatever the direction holds
		send(mk(ritd_pkg::REQ_WRITE, ritd_pkg::ADDR_PA_DATA, 8'hFF));
		send(mk(ritd_pkg::REQ_WRITE, ritd_pkg::ADDR_PA_DIR, 8'h55));
		send(mk(ritd_pkg::REQ_WRITE, ritd_pkg::ADDR_PB_DATA, 8'hAA));
		send(mk(ritd_pkg::REQ_WRITE, ritd_pkg::ADDR_PB_DIR, 8'hFF));
		send(mk(ritd_pkg::REQ_READ, ritd_pkg::ADDR_PA_DIR, 8'h00));
		send(mk(ritd_pkg::REQ_READ, ritd_pkg::ADDR_PB_DIR, 8'h00));
		// Unmapped offsets and the unknown request kind
		send(mk(ritd_pkg::REQ_WRITE, ritd_pkg::ADDR_FLAG, 8'hFF));
		send(mk(ritd_pkg::REQ_READ, 8'hFF, 8'h00));
		send(mk(ritd_pkg::REQ_READ, 8'h84, 8'h00));
		send(mk(REQ_UNKNOWN, 8'hFF, 8'hFF));
		// Expiry with interrupt, count-down past expiry, flag read clears
		send(mk(ritd_pkg::REQ_WRITE, ritd_pkg::ADDR_TMRI_LO, 8'h01));
		send(mk(ritd_pkg::REQ_TICK, 8'h00, 8'h00));
		send(mk(ritd_pkg::REQ_TICK, 8'h00, 8'h00));
		send(mk(ritd_pkg::REQ_TICK, 8'h00, 8'h00));
		send(mk(ritd_pkg::REQ_READ, ritd_pkg::ADDR_FLAG, 8'h00));
		send(mk(ritd_pkg::REQ_READ, ritd_pkg::ADDR_FLAG, 8'h00));
		send(mk(ritd_pkg::REQ_WRITE, ritd_pkg::ADDR_TMR_HI, 8'hFF));
		send(mk(ritd_pkg::REQ_TICK, 8'hFF, 8'hFF));
		send(mk(ritd_pkg::REQ_WRITE, ritd_pkg::ADDR_TMRI_HI, 8'h00));

		rand_sent = 0;
		while (rand_sent < RAND_ITEMS) begin
			phase = rand_sent * 4 / RAND_ITEMS;
			case (phase)
				0: begin idle_pct = 0;  stall_pct = 0;  end
				1: begin idle_pct = 57; stall_pct = 0;  end
				2: begin idle_pct = 0;  stall_pct = 57; end
				default: begin idle_pct = 32; stall_pct = 32; end
			endcase
			pick = $urandom_range(99);
			if (pick < 50) begin
				timer_run();
			end else if (pick < 75) begin
				n = $urandom_range(10, 4);
				for (i = 0; i < n; i++)
					misc_access();
			end else begin
				n = $urandom_range(6, 1);
				for (i = 0; i < n; i++)
					send(mk(2'($urandom_range(3)), 8'($urandom_range(255)),
						8'($urandom_range(255))));
			end
		end
		s_tvalid <= 1'b0;

		n = 0;
		while (sb.outstanding() != 0 && n < 10000) begin
			@(posedge clk);
			n++;
		end
		repeat (10) @(posedge clk);
		if (sb.outstanding() != 0) begin
			$display("%0t: %0d results never arrived", $time, sb.outstanding());
			sb.errors++;
		end
		if (sb.errors == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

	initial begin
		#2_000_000;
		$display("== FAIL ==");
		$finish;
	end

endmodule
